>>> design/tcce_pkg.sv
// shared types and constants of the text console character engine
package tcce_pkg;

   localparam logic [7:0]  NL_CODE    = 8'd10;
   localparam logic [7:0]  BS_CODE    = 8'd8;
   localparam logic [7:0]  SPACE_CODE = 8'h20;
   localparam logic [7:0]  ATTR_RESET = 8'h07;
   localparam logic [15:0] RESET_CELL = 16'h0720;

   typedef enum logic [2:0] {
      OP_READ,
      OP_NOP,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_PRINT
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_code;
      logic        in_range;
   } tcce_cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_RUN,
      BK_BLANK
   } bk_state_type;

   typedef struct packed {
      logic clearing;
      logic blanking;
   } bk_status_type;

endpackage

>>> design/tcce_front.sv
// front end: takes words, classifies them and hands them to the queue
module tcce_front
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int LIN_W   = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [7:0]         req_char_code,
   input  logic [4:0]         req_read_row,
   input  logic [6:0]         req_read_col,
   input  logic               clearing,
   input  logic               q_ready,
   output logic               q_push,
   output tcce_cmd_type       q_cmd,
   output logic [LIN_W-1:0]   q_lin
);

   logic              fr_valid_ff, fr_valid_in;
   tcce_cmd_type      fr_cmd_ff, fr_cmd_in;
   logic [LIN_W-1:0]  fr_lin_ff, fr_lin_in;
   logic              take;

   assign busy  = clearing || (fr_valid_ff && !q_ready);
   assign take  = start && !busy;

   always_comb begin
      fr_cmd_in.char_code = req_char_code;
      fr_cmd_in.in_range  = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
      if (req_func) begin
         fr_cmd_in.kind = OP_READ;
      end else if (req_char_code == 8'd0) begin
         fr_cmd_in.kind = OP_NOP;
      end else if (req_char_code == NL_CODE) begin
         fr_cmd_in.kind = OP_NEWLINE;
      end else if (req_char_code == BS_CODE) begin
         fr_cmd_in.kind = OP_BACKSPACE;
      end else begin
         fr_cmd_in.kind = OP_PRINT;
      end
      // logical cell index of the read, row major
      fr_lin_in = LIN_W'(32'(req_read_row) * COLUMNS + 32'(req_read_col));
   end

   always_comb begin
      if (take) begin
         fr_valid_in = 1'b1;
      end else if (fr_valid_ff && q_ready) begin
         fr_valid_in = 1'b0;
      end else begin
         fr_valid_in = fr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fr_cmd_ff <= fr_cmd_in;
         fr_lin_ff <= fr_lin_in;
      end
   end

   assign q_push = fr_valid_ff;
   assign q_cmd  = fr_cmd_ff;
   assign q_lin  = fr_lin_ff;

endmodule

>>> design/tcce_queue.sv
// two-entry queue between the front end and the back end
module tcce_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/tcce_back.sv
// back end: screen memory, cursor, scroll ring and result strobe
module tcce_back
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int LIN_W   = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        attr,
   input  logic              q_valid,
   output logic              q_pop,
   input  tcce_cmd_type      q_cmd,
   input  logic [LIN_W-1:0]  q_lin,
   output bk_status_type     status,
   output logic              rsp_valid,
   output logic              rsp_accepted,
   output logic [10:0]       rsp_cursor_pos,
   output logic [15:0]       rsp_cell_value,
   output logic              rsp_scrolled
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int SUM_W = LIN_W + 1;
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [LIN_W-1:0] BOTTOM_LIN = LIN_W'((ROWS - 1) * COLUMNS);
   localparam logic [LIN_W-1:0] LAST_CELL  = LIN_W'(CELLS - 1);

   logic [15:0] mem [CELLS];
   logic [15:0] rd_data_ff;

   bk_state_type     state_ff, state_in;
   logic [LIN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [LIN_W-1:0] lin_ff, lin_in;
   logic [LIN_W-1:0] top_ff, top_in;
   logic [COL_W-1:0] blank_cnt_ff, blank_cnt_in;
   logic [LIN_W-1:0] blank_addr_ff, blank_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff, rsp_acc_in;
   logic             rsp_scr_ff, rsp_scr_in;
   logic             rsp_mem_ff, rsp_mem_in;

   logic             we, re, scroll_go, run_pop;
   logic [LIN_W-1:0] waddr, raddr, bs_lin, top_next;
   logic [15:0]      wdata;
   logic [SUM_W-1:0] top_sum;

   // logical index plus ring offset, folded back into the memory
   function automatic logic [LIN_W-1:0] to_phys(input logic [LIN_W-1:0] a,
                                                 input logic [LIN_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SUM_W'(CELLS)) begin
         s = s - SUM_W'(CELLS);
      end
      return s[LIN_W-1:0];
   endfunction

   assign run_pop = (state_ff == BK_RUN) && q_valid;
   assign q_pop   = run_pop;
   assign top_sum = {1'b0, top_ff} + SUM_W'(COLUMNS);
   assign top_next = (top_sum == SUM_W'(CELLS)) ? '0 : top_sum[LIN_W-1:0];
   assign bs_lin  = (lin_ff == '0) ? '0 : lin_ff - LIN_W'(1);

   always_comb begin
      scroll_go = 1'b0;
      if (run_pop && row_ff == LAST_ROW) begin
         if (q_cmd.kind == OP_NEWLINE) begin
            scroll_go = 1'b1;
         end else if (q_cmd.kind == OP_PRINT && col_ff == LAST_COL) begin
            scroll_go = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_cnt_ff == LAST_CELL) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (scroll_go) begin
               state_in = BK_BLANK;
            end
         end
         BK_BLANK: begin
            if (blank_cnt_ff == LAST_COL) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      re            = 1'b0;
      raddr         = '0;
      clr_cnt_in    = clr_cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      lin_in        = lin_ff;
      top_in        = top_ff;
      blank_cnt_in  = blank_cnt_ff;
      blank_addr_in = blank_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_acc_in    = rsp_acc_ff;
      rsp_scr_in    = rsp_scr_ff;
      rsp_mem_in    = rsp_mem_ff;
      case (state_ff)
         BK_CLEAR: begin
            we         = 1'b1;
            waddr      = clr_cnt_ff;
            wdata      = RESET_CELL;
            clr_cnt_in = clr_cnt_ff + LIN_W'(1);
         end
         BK_BLANK: begin
            we            = 1'b1;
            waddr         = blank_addr_ff;
            wdata         = {attr, SPACE_CODE};
            blank_addr_in = blank_addr_ff + LIN_W'(1);
            blank_cnt_in  = blank_cnt_ff + COL_W'(1);
            rsp_valid_in  = (blank_cnt_ff == LAST_COL);
         end
         BK_RUN: begin
            if (run_pop) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b1;
               rsp_scr_in   = 1'b0;
               rsp_mem_in   = 1'b0;
               case (q_cmd.kind)
                  OP_READ: begin
                     re         = 1'b1;
                     raddr      = to_phys(q_lin, top_ff);
                     rsp_acc_in = 1'b0;
                     rsp_mem_in = q_cmd.in_range;
                  end
                  OP_NOP: begin
                     rsp_acc_in = 1'b0;
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (row_ff != LAST_ROW) begin
                        row_in = row_ff + ROW_W'(1);
                        lin_in = lin_ff - LIN_W'(col_ff) + LIN_W'(COLUMNS);
                     end else begin
                        lin_in = BOTTOM_LIN;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end else if (row_ff != '0) begin
                        row_in = row_ff - ROW_W'(1);
                        col_in = LAST_COL;
                     end
                     lin_in = bs_lin;
                     we     = 1'b1;
                     waddr  = to_phys(bs_lin, top_ff);
                     wdata  = {attr, SPACE_CODE};
                  end
                  OP_PRINT: begin
                     we    = 1'b1;
                     waddr = to_phys(lin_ff, top_ff);
                     wdata = {attr, q_cmd.char_code};
                     if (col_ff != LAST_COL) begin
                        col_in = col_ff + COL_W'(1);
                        lin_in = lin_ff + LIN_W'(1);
                     end else begin
                        col_in = '0;
                        if (row_ff != LAST_ROW) begin
                           row_in = row_ff + ROW_W'(1);
                           lin_in = lin_ff + LIN_W'(1);
                        end else begin
                           lin_in = BOTTOM_LIN;
                        end
                     end
                  end
                  default: begin
                     rsp_acc_in = 1'b0;
                  end
               endcase
               if (scroll_go) begin
                  // old top row becomes the new bottom row and is blanked
                  rsp_valid_in  = 1'b0;
                  rsp_scr_in    = 1'b1;
                  top_in        = top_next;
                  blank_addr_in = top_ff;
                  blank_cnt_in  = '0;
               end
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         top_ff       <= '0;
         blank_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_mem_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         top_ff       <= top_in;
         blank_cnt_ff <= blank_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mem_ff   <= rsp_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      blank_addr_ff <= blank_addr_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_scr_ff    <= rsp_scr_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign status.clearing = (state_ff == BK_CLEAR);
   assign status.blanking = (state_ff == BK_BLANK);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_scrolled   = rsp_scr_ff;
   assign rsp_cursor_pos = 11'(lin_ff);
   assign rsp_cell_value = rsp_mem_ff ? rd_data_ff : 16'd0;

endmodule

>>> design/text_console_char_engine_core.sv
// top level of the text console character engine
//
// usage
//   - a command word is taken at a rising edge with start high and busy low;
//     func 0 puts char_code at the cursor (0 is ignored, 10 is a newline,
//     8 a backspace), func 1 reads the cell at read_row / read_col
//   - every command gives one result word: rsp_valid is high for exactly one
//     cycle with accepted, cursor_pos, cell_value and scrolled alongside;
//     the receiver cannot hold it off, so it must take it that cycle
//   - csr_we / csr_wdata write the text attribute (reset 7), used for every
//     printed and blanked cell; write it only while no command is pending
// timing
//   - a command passes the front-end register, the queue and the registered
//     result strobe; a full queue or a row blanking can hold it up
//   - outside row blanking the back end runs one command a cycle, so words
//     can be taken every cycle while the two-entry queue has room
//   - a scroll blanks one row through the single memory write port before
//     that result strobes
//   - the screen is a ring of rows in one memory; scrolling moves the top
//     row pointer instead of copying cells
// reset
//   - cursor goes to the top-left cell and a clearing pass writes attribute
//     7 space into all ROWS * COLUMNS cells while busy stays high; csr
//     writes are taken during that pass
module text_console_char_engine_core
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic [10:0] rsp_cursor_pos,
   output logic [15:0] rsp_cell_value,
   output logic        rsp_scrolled,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int LIN_W = $clog2(ROWS * COLUMNS);
   localparam int Q_W   = $bits(tcce_cmd_type) + LIN_W;

   // text attribute register
   logic [7:0] attr_ff, attr_in;

   // front end to queue
   logic             fr_push, q_ready;
   tcce_cmd_type     fr_cmd;
   logic [LIN_W-1:0] fr_lin;

   // queue to back end
   logic             q_valid, q_pop;
   logic [Q_W-1:0]   q_out;
   tcce_cmd_type     q_cmd;
   logic [LIN_W-1:0] q_lin;

   bk_status_type    bk_status;

   assign attr_in = csr_we ? csr_wdata : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // classify words and stage them for the queue
   tcce_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .LIN_W   (LIN_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .clearing      (bk_status.clearing),
      .q_ready       (q_ready),
      .q_push        (fr_push),
      .q_cmd         (fr_cmd),
      .q_lin         (fr_lin)
   );

   // decouples the front end from scrolls in the back end
   tcce_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_push),
      .push_ready (q_ready),
      .push_data  ({fr_cmd, fr_lin}),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out)
   );

   assign {q_cmd, q_lin} = q_out;

   // executes commands against the screen memory
   tcce_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .LIN_W   (LIN_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .attr           (attr_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd),
      .q_lin          (q_lin),
      .status         (bk_status),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled)
   );

   // no command is taken during the clearing pass
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      bk_status.clearing |-> busy)
      else $error("command taken during clearing pass");

   // a scroll always leaves the cursor at the start of the bottom row
   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_pos == 11'((ROWS - 1) * COLUMNS)))
      else $error("scroll result with cursor off the bottom row start");

   // only handled characters can scroll
   a_scroll_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> !rsp_scrolled)
      else $error("scroll reported for an unhandled word");

   // no result strobes while a row is still being blanked
   a_blank_quiet: assert property (@(posedge clock) disable iff (reset)
      (bk_status.blanking && $past(bk_status.blanking)) |-> !rsp_valid)
      else $error("result strobed during row blanking");

endmodule
